FILE: hw/rtl/dibp_pkg.sv
// Shared types, register indexes and color helpers for the dithered palette blitter.
`default_nettype none

package dibp_pkg;

  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 13;
  localparam int CfgDimW = 13;
  localparam int OriginW = 12;
  localparam int AddrW = 24;
  localparam int LevelW = 3;

  localparam logic [CfgIdxW-1:0] CFG_SCREEN_WIDTH = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ORIGIN_X     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ORIGIN_Y     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_WIDTH  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_HEIGHT = 3'd4;

  localparam logic [CfgDimW-1:0] SCREEN_WIDTH_RST = 13'd320;
  localparam logic [CfgDimW-1:0] IMAGE_DIM_RST    = 13'd1;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct packed {
    logic [AddrW-1:0] pixel_address;
    logic [7:0]       color_index;
    logic             last_pixel;
  } result_t;

  // 2x2 ordered dither, indexed by (x&1) + 2*(y&1)
  function automatic logic [1:0] dither_value(input logic x0, input logic y0);
    logic [1:0] sel;
    logic [1:0] d;
    sel = {y0, x0};
    case (sel)
      2'd0: d = 2'd3;
      2'd1: d = 2'd1;
      2'd2: d = 2'd0;
      2'd3: d = 2'd2;
      default: d = 2'd0;
    endcase
    return d;
  endfunction

  // ((c*21 >> 8) + d) >> 2, range 0..5
  function automatic logic [LevelW-1:0] to_level(input logic [7:0] c, input logic [1:0] d);
    logic [12:0] prod;
    logic [4:0]  scaled;
    logic [5:0]  sum;
    prod = ({5'd0, c} << 4) + ({5'd0, c} << 2) + {5'd0, c};
    scaled = prod[12:8];
    sum = {1'b0, scaled} + {4'd0, d};
    return sum[4:2];
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/dibp_pos.sv
// Column/row counters and the screen position of the incoming pixel.
`default_nettype none

module dibp_pos #(
  parameter int MAX_DIM = 4096,
  parameter int PosW = 13
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          advance,
  input  wire logic [dibp_pkg::OriginW-1:0]  origin_x,
  input  wire logic [dibp_pkg::OriginW-1:0]  origin_y,
  input  wire logic [dibp_pkg::CfgDimW-1:0]  image_width,
  input  wire logic [dibp_pkg::CfgDimW-1:0]  image_height,
  output logic      [PosW-1:0]               x,
  output logic      [PosW-1:0]               y,
  output logic                               last
);
  import dibp_pkg::*;

  localparam int CntW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DimW = $clog2(MAX_DIM + 1);
  localparam int CmpW = ((DimW > CfgDimW) ? DimW : CfgDimW) + 1;

  logic [CntW-1:0] column_count;
  logic [CntW-1:0] row_count;
  logic [CntW-1:0] column_count_next;
  logic [CntW-1:0] row_count_next;
  logic [CmpW-1:0] w;
  logic [CmpW-1:0] h;
  logic            row_end;

  function automatic logic [CmpW-1:0] clamp_dim(input logic [CfgDimW-1:0] v);
    logic [CmpW-1:0] ve;
    ve = CmpW'(v);
    if (ve == '0) begin
      return CmpW'(1);
    end else if (ve > CmpW'(MAX_DIM)) begin
      return CmpW'(MAX_DIM);
    end
    return ve;
  endfunction

  always_comb begin
    w = clamp_dim(image_width);
    h = clamp_dim(image_height);
    x = PosW'(origin_x) + PosW'(column_count);
    y = PosW'(origin_y) + PosW'(row_count);
    row_end = (CmpW'(column_count) + CmpW'(1)) >= w;
    last = row_end && ((CmpW'(row_count) + CmpW'(1)) >= h);
    if (row_end) begin
      column_count_next = '0;
      row_count_next = last ? '0 : row_count + CntW'(1);
    end else begin
      column_count_next = column_count + CntW'(1);
      row_count_next = row_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count <= '0;
    end else if (advance) begin
      column_count <= column_count_next;
      row_count <= row_count_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/dibp_conv.sv
// Dither, palette quantization and framebuffer address for one registered pixel.
`default_nettype none

module dibp_conv #(
  parameter int PosW = 13
) (
  input  wire dibp_pkg::pixel_t               pix,
  input  wire logic [PosW-1:0]                x,
  input  wire logic [PosW-1:0]                y,
  input  wire logic                           last,
  input  wire logic [dibp_pkg::CfgDimW-1:0]   screen_width,
  output dibp_pkg::result_t                   res
);
  import dibp_pkg::*;

  localparam int ProdW = CfgDimW + PosW;

  logic [1:0]        d;
  logic [LevelW-1:0] lr;
  logic [LevelW-1:0] lg;
  logic [LevelW-1:0] lb;
  logic [ProdW:0]    addr_full;

  always_comb begin
    d = dither_value(x[0], y[0]);
    lr = to_level(pix.red, d);
    lg = to_level(pix.green, d);
    lb = to_level(pix.blue, d);
    addr_full = (ProdW + 1)'(screen_width) * (ProdW + 1)'(y) + (ProdW + 1)'(x);
    res.pixel_address = addr_full[AddrW-1:0];
    // b*36 + g*6 + r
    res.color_index = ({5'd0, lb} << 5) + ({5'd0, lb} << 2)
                    + ({5'd0, lg} << 2) + ({5'd0, lg} << 1) + {5'd0, lr};
    res.last_pixel = last;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/dithered_image_blit_to_palette.sv
// Top level: 2x2 ordered-dither RGB blit to a 6x6x6 palette framebuffer.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+-------------------------------
//   pixel    | in        | pixel_valid/stall    | pixel_t {blue, green, red}
//   result   | out       | result_valid/stall   | result_t {address, index, last}
//   cfg      | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// One item per clock while result_stall is low; an accepted pixel passes through the input
// register, then the result register after the address multiplier.
// Synchronous reset clears counters, pipeline valids and loads register defaults.
// Each stage holds while the stage after it is full and stalled; pixel_stall
// rises only when both stages are full and result_stall is high.
// cfg_ready is always high.
`default_nettype none

module dithered_image_blit_to_palette #(
  parameter int MAX_DIM = 4096
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           pixel_valid,
  output logic                                pixel_stall,
  input  wire dibp_pkg::pixel_t               pixel,
  output logic                                result_valid,
  input  wire logic                           result_stall,
  output dibp_pkg::result_t                   result,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [dibp_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [dibp_pkg::CfgDataW-1:0]  cfg_data
);
  import dibp_pkg::*;

  localparam int CntW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int PosW = ((CntW > OriginW) ? CntW : OriginW) + 1;

  logic [CfgDimW-1:0]  screen_width;
  logic [OriginW-1:0]  origin_x;
  logic [OriginW-1:0]  origin_y;
  logic [CfgDimW-1:0]  image_width;
  logic [CfgDimW-1:0]  image_height;

  logic                pixel_take;
  logic                s1_adv;
  logic [PosW-1:0]     pos_x;
  logic [PosW-1:0]     pos_y;
  logic                pos_last;

  logic                s1_valid;
  pixel_t              s1_pix;
  logic [PosW-1:0]     s1_x;
  logic [PosW-1:0]     s1_y;
  logic                s1_last;
  result_t             conv_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width <= SCREEN_WIDTH_RST;
      origin_x <= '0;
      origin_y <= '0;
      image_width <= IMAGE_DIM_RST;
      image_height <= IMAGE_DIM_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SCREEN_WIDTH: screen_width <= cfg_data;
        CFG_ORIGIN_X:     origin_x <= cfg_data[OriginW-1:0];
        CFG_ORIGIN_Y:     origin_y <= cfg_data[OriginW-1:0];
        CFG_IMAGE_WIDTH:  image_width <= cfg_data;
        CFG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s1_adv = !result_valid || !result_stall;
  assign pixel_stall = s1_valid && !s1_adv;
  assign pixel_take = pixel_valid && !pixel_stall;

  dibp_pos #(
    .MAX_DIM (MAX_DIM),
    .PosW    (PosW)
  ) u_pos (
    .clk          (clk),
    .rst          (rst),
    .advance      (pixel_take),
    .origin_x     (origin_x),
    .origin_y     (origin_y),
    .image_width  (image_width),
    .image_height (image_height),
    .x            (pos_x),
    .y            (pos_y),
    .last         (pos_last)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!pixel_stall) begin
      s1_valid <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_take) begin
      s1_pix <= pixel;
      s1_x <= pos_x;
      s1_y <= pos_y;
      s1_last <= pos_last;
    end
  end

  dibp_conv #(
    .PosW (PosW)
  ) u_conv (
    .pix          (s1_pix),
    .x            (s1_x),
    .y            (s1_y),
    .last         (s1_last),
    .screen_width (screen_width),
    .res          (conv_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      result <= conv_res;
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> (s1_valid && result_valid && result_stall))
    else $error("pixel_stall with a free pipeline slot");

  a_stage1_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_x) && $stable(s1_y)
                               && $stable(s1_pix) && $stable(s1_last)))
    else $error("held stage-1 item changed");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.color_index <= 8'd215))
    else $error("palette index out of range");

endmodule

`default_nettype wire

FILE: verif/dithered_image_blit_to_palette_tb.sv
// Testbench for the 2x2 ordered-dither palette blitter: directed and random pixel streams.
`timescale 1ns / 1ps

module dithered_image_blit_to_palette_tb;
  import dibp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int unsigned DIM_CAP = 4096;
  localparam int unsigned DITHER_2X2[4] = '{3, 1, 0, 2};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pixel_valid = 1'b0;
  logic pixel_stall;
  pixel_t pixel = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  dithered_image_blit_to_palette dut (
    .clk(clk),
    .rst(rst),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .pixel(pixel),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // shadow registers and image position
  logic [CfgDimW-1:0] scr_width = SCREEN_WIDTH_RST;
  logic [OriginW-1:0] org_x = '0;
  logic [OriginW-1:0] org_y = '0;
  logic [CfgDimW-1:0] img_w = IMAGE_DIM_RST;
  logic [CfgDimW-1:0] img_h = IMAGE_DIM_RST;
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;

  result_t fb_writes[$];
  bit bursts_on = 1'b1;
  int mismatches = 0;
  int pixels_sent = 0;
  int cycle_count = 0;
  int stall_left = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int unsigned eff_dim(input logic [CfgDimW-1:0] v);
    if (v == 0) return 1;
    if (v > DIM_CAP) return DIM_CAP;
    return v;
  endfunction

  function automatic int unsigned channel_level(input logic [7:0] c, input int unsigned d);
    int unsigned cv;
    cv = c;
    return (((cv * 21) >> 8) + d) >> 2;
  endfunction

  // computes the framebuffer write for one pixel and advances the position
  function automatic result_t place_and_dither(input pixel_t p);
    result_t r;
    int unsigned w, h, x, y, d;
    longint unsigned a;
    bit row_end, last;
    w = eff_dim(img_w);
    h = eff_dim(img_h);
    x = org_x + col_pos;
    y = org_y + row_pos;
    d = DITHER_2X2[(x & 1) + 2 * (y & 1)];
    a = longint'(scr_width) * y + x;
    row_end = (col_pos + 1) >= w;
    last = row_end && ((row_pos + 1) >= h);
    if (row_end) begin
      col_pos = 0;
      row_pos = last ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    r.pixel_address = AddrW'(a);
    r.color_index = 8'(channel_level(p.blue, d) * 36 + channel_level(p.green, d) * 6
                       + channel_level(p.red, d));
    r.last_pixel = last;
    return r;
  endfunction

  function automatic pixel_t mk_pixel(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b);
    pixel_t p;
    p.red = r;
    p.green = g;
    p.blue = b;
    return p;
  endfunction

  function automatic logic [7:0] rand_channel();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [CfgDataW-1:0] rand_dim();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return CfgDataW'(DIM_CAP);
      2: return '1;
      3: return CfgDataW'($urandom);
      default: return CfgDataW'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic logic [CfgDataW-1:0] rand_screen_width();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return CfgDataW'(1);
      2: return '1;
      3: return SCREEN_WIDTH_RST;
      default: return CfgDataW'($urandom);
    endcase
  endfunction

  function automatic logic [CfgDataW-1:0] rand_origin();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return CfgDataW'({OriginW{1'b1}});
      2: return '1;
      default: return CfgDataW'($urandom);
    endcase
  endfunction

  task automatic set_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SCREEN_WIDTH: scr_width = val;
      CFG_ORIGIN_X: org_x = val[OriginW-1:0];
      CFG_ORIGIN_Y: org_y = val[OriginW-1:0];
      CFG_IMAGE_WIDTH: img_w = val;
      CFG_IMAGE_HEIGHT: img_h = val;
      default: ;
    endcase
  endtask

  task automatic send_pixel(input pixel_t p);
    cfg_valid <= 1'b0;
    if (bursts_on && $urandom_range(0, 5) == 0) begin
      pixel_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel <= p;
    do @(posedge clk); while (pixel_stall);
    fb_writes.push_back(place_and_dither(p));
    pixels_sent++;
  endtask

  task automatic drain();
    pixel_valid <= 1'b0;
    while (fb_writes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic report(input string what, input longint unsigned want,
                        input longint unsigned got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch in %s: expected 0x%0h, got 0x%0h", what, want, got);
  endtask

  task automatic test_reset_config();
    send_pixel(mk_pixel(8'h00, 8'h00, 8'h00));
    send_pixel(mk_pixel(8'hFF, 8'hFF, 8'hFF));
    send_pixel(mk_pixel(8'd13, 8'd12, 8'd200));
  endtask

  task automatic test_dither_phases();
    drain();
    set_reg(CFG_IMAGE_WIDTH, 13'd2);
    set_reg(CFG_IMAGE_HEIGHT, 13'd2);
    repeat (4) send_pixel(mk_pixel(8'd128, 8'd128, 8'd128));
    drain();
    set_reg(CFG_ORIGIN_X, 13'd1);
    set_reg(CFG_ORIGIN_Y, 13'd1);
    send_pixel(mk_pixel(8'd60, 8'd120, 8'd180));
    send_pixel(mk_pixel(8'd37, 8'd74, 8'd111));
    send_pixel(mk_pixel(8'd180, 8'd120, 8'd60));
    send_pixel(mk_pixel(8'd49, 8'd98, 8'd245));
  endtask

  task automatic test_dim_limits();
    drain();
    set_reg(CFG_IMAGE_WIDTH, '0);
    set_reg(CFG_IMAGE_HEIGHT, '0);
    send_pixel(mk_pixel(8'd1, 8'd2, 8'd3));
    drain();
    set_reg(CFG_IMAGE_WIDTH, '1);
    set_reg(CFG_IMAGE_HEIGHT, '1);
    repeat (3) send_pixel(mk_pixel(rand_channel(), rand_channel(), rand_channel()));
    drain();
    // shrink the row below the current column
    set_reg(CFG_IMAGE_WIDTH, 13'd2);
    send_pixel(mk_pixel(8'd250, 8'd5, 8'd90));
    send_pixel(mk_pixel(8'd90, 8'd250, 8'd5));
    drain();
    // shrink both bounds below the current position
    set_reg(CFG_IMAGE_WIDTH, 13'd1);
    set_reg(CFG_IMAGE_HEIGHT, 13'd1);
    send_pixel(mk_pixel(8'd5, 8'd90, 8'd250));
  endtask

  task automatic test_address_wrap();
    drain();
    set_reg(CFG_SCREEN_WIDTH, '1);
    set_reg(CFG_ORIGIN_X, '1);
    set_reg(CFG_ORIGIN_Y, CfgDataW'({OriginW{1'b1}}));
    send_pixel(mk_pixel(8'd77, 8'd166, 8'd233));
    drain();
    set_reg(CFG_SCREEN_WIDTH, '0);
    send_pixel(mk_pixel(8'd233, 8'd77, 8'd166));
  endtask

  task automatic test_spare_index();
    drain();
    for (int i = CFG_IMAGE_HEIGHT + 1; i < (1 << CfgIdxW); i++)
      set_reg(CfgIdxW'(i), '1);
    send_pixel(mk_pixel(8'd100, 8'd150, 8'd200));
    send_pixel(mk_pixel(8'd200, 8'd150, 8'd100));
  endtask

  task automatic random_config();
    if ($urandom_range(0, 3) != 0) set_reg(CFG_SCREEN_WIDTH, rand_screen_width());
    if ($urandom_range(0, 3) != 0) set_reg(CFG_ORIGIN_X, rand_origin());
    if ($urandom_range(0, 3) != 0) set_reg(CFG_ORIGIN_Y, rand_origin());
    if ($urandom_range(0, 3) != 0) set_reg(CFG_IMAGE_WIDTH, rand_dim());
    if ($urandom_range(0, 3) != 0) set_reg(CFG_IMAGE_HEIGHT, rand_dim());
  endtask

  task automatic test_random_images();
    int n;
    while (pixels_sent < 480) begin
      drain();
      random_config();
      bursts_on = ($urandom_range(0, 3) != 0);
      n = $urandom_range(8, 48);
      repeat (n) send_pixel(mk_pixel(rand_channel(), rand_channel(), rand_channel()));
    end
  endtask

  task automatic test_full_rate();
    bursts_on = 1'b0;
    drain();
    set_reg(CFG_SCREEN_WIDTH, rand_screen_width());
    set_reg(CFG_ORIGIN_X, rand_origin());
    set_reg(CFG_ORIGIN_Y, rand_origin());
    set_reg(CFG_IMAGE_WIDTH, CfgDataW'($urandom_range(1, 12)));
    set_reg(CFG_IMAGE_HEIGHT, CfgDataW'($urandom_range(1, 12)));
    repeat (120) send_pixel(mk_pixel(rand_channel(), rand_channel(), rand_channel()));
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (!bursts_on) stall_left = 0;
      else if (stall_left != 0) stall_left--;
      else if ($urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 8);
      result_stall <= (stall_left != 0);
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (fb_writes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result 0x%0h with nothing pending", result);
      end else begin
        want = fb_writes.pop_front();
        if (result.pixel_address !== want.pixel_address)
          report("pixel_address", want.pixel_address, result.pixel_address);
        if (result.color_index !== want.color_index)
          report("color_index", want.color_index, result.color_index);
        if (result.last_pixel !== want.last_pixel)
          report("last_pixel", want.last_pixel, result.last_pixel);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_config();
    test_dither_phases();
    test_dim_limits();
    test_address_wrap();
    test_spare_index();
    test_random_images();
    test_full_rate();
    cfg_valid <= 1'b0;
    drain();
    repeat (4) @(posedge clk);
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
